### src/pidv_pkg.sv
package pidv_pkg;

    // Gains are unsigned Q16.16.
    localparam int GAIN_W = 32;

    // The configuration data bus is as wide as the widest register (the gains).
    localparam int CFG_DATA_W = 32;

    // Duty is a 0.16 fraction of the Q.28 control value.
    localparam int DUTY_W     = 16;
    localparam int FRAC_SHIFT = 12;
    localparam int CLIP_BIT   = FRAC_SHIFT + DUTY_W;

    // Register map of the configuration port.
    typedef logic [1:0] reg_index_t;

    localparam reg_index_t REG_PROP_GAIN   = 2'd0;
    localparam reg_index_t REG_INTEG_GAIN  = 2'd1;
    localparam reg_index_t REG_DERIV_GAIN  = 2'd2;
    localparam reg_index_t REG_TARGET      = 2'd3;

    // Reset values of the gains: 0.1, 0.001 and 0.1 in Q16.16.
    localparam logic [GAIN_W-1:0] PROP_GAIN_RESET  = 32'd6554;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RESET = 32'd66;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RESET = 32'd6554;

    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] deriv;
    } gains_t;

endpackage

### src/pid_velocity_controller.sv
// PID speed controller. Each beat on the s_ channel is one control tick carrying
// the measured angular velocity in signed Q12.12; each beat on the m_ channel
// is the answer for that tick: a direction bit (1 when the control value is
// strictly positive) and the control magnitude as an unsigned 0.16 duty
// fraction, clipped at 65535 when the magnitude reaches 1.0. The controller
// forms error = target - measured, adds it to a saturating integral of
// SUM_WIDTH bits and takes the difference from the previous error; control is
// the exact sum of the three gain products, with Q16.16 gains that already
// include the control period. The block accepts one beat every clock while
// m_ready keeps the results draining. The accepting edge loads the input
// register, and the integrator, multiplier, adder and magnitude-and-clipping
// registers follow in that order; the last of them drives m_valid. Backpressure
// on m_ready fills the pipeline one stage at a time before s_ready drops. Gains
// and the target are written through the cfg_ port, one register per cycle,
// and should only be changed while no ticks are in flight. Reset clears the
// integral and the previous error and restores the default gains
// (0.1, 0.001, 0.1) and a target of zero.
module pid_velocity_controller #(
    parameter int SPEED_WIDTH = 24,
    parameter int SUM_WIDTH   = 40
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SPEED_WIDTH-1:0]       s_measured_speed,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_direction,
    output logic [pidv_pkg::DUTY_W-1:0]         m_duty,

    input  logic                                cfg_we,
    input  pidv_pkg::reg_index_t                cfg_index,
    input  logic [pidv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import pidv_pkg::*;

    localparam int LO_W = SUM_WIDTH / 2;

    // Configuration registers.
    gains_t                        gains_reg;
    logic signed [SPEED_WIDTH-1:0] target_reg;

    // Input register.
    logic                          in_valid_reg;
    logic signed [SPEED_WIDTH-1:0] meas_reg;

    // Stage handshakes.
    logic                          integ_ready;
    logic                          integ_valid;
    logic                          prod_ready;
    logic                          prod_valid;
    logic                          res_ready;

    // Stage payloads.
    logic signed [SPEED_WIDTH:0]            err;
    logic signed [SPEED_WIDTH+1:0]          diff;
    logic signed [SUM_WIDTH-1:0]            sum;
    logic signed [GAIN_W+SPEED_WIDTH+1:0]   prop_prod;
    logic signed [GAIN_W+SPEED_WIDTH+2:0]   deriv_prod;
    logic signed [GAIN_W+SUM_WIDTH-LO_W:0]  integ_hi_prod;
    logic        [GAIN_W+LO_W-1:0]          integ_lo_prod;

    // Register writes. The target is taken from the low bits of the data bus
    // and read as a signed value of the speed width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg.prop  <= PROP_GAIN_RESET;
            gains_reg.integ <= INTEG_GAIN_RESET;
            gains_reg.deriv <= DERIV_GAIN_RESET;
            target_reg      <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PROP_GAIN:  gains_reg.prop  <= cfg_wdata[GAIN_W-1:0];
                REG_INTEG_GAIN: gains_reg.integ <= cfg_wdata[GAIN_W-1:0];
                REG_DERIV_GAIN: gains_reg.deriv <= cfg_wdata[GAIN_W-1:0];
                REG_TARGET:     target_reg      <= $signed(cfg_wdata[SPEED_WIDTH-1:0]);
                default: begin
                end
            endcase
        end
    end

    // The input register takes a new beat whenever the integrator stage can
    // take the one it holds, so the input side is never held up by a result
    // that is only waiting at the output.
    assign s_ready = !in_valid_reg || integ_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            meas_reg <= s_measured_speed;
        end
    end

    // Error, derivative difference and saturating integral; this stage also
    // holds the controller state.
    pidv_integrator #(
        .SPEED_WIDTH (SPEED_WIDTH),
        .SUM_WIDTH   (SUM_WIDTH)
    ) u_integrator (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (integ_ready),
        .measured  (meas_reg),
        .target    (target_reg),
        .out_valid (integ_valid),
        .out_ready (prod_ready),
        .err       (err),
        .diff      (diff),
        .sum       (sum)
    );

    // The three gain products, the integral one in two halves.
    pidv_products #(
        .SPEED_WIDTH (SPEED_WIDTH),
        .SUM_WIDTH   (SUM_WIDTH)
    ) u_products (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (integ_valid),
        .in_ready      (prod_ready),
        .err           (err),
        .diff          (diff),
        .sum           (sum),
        .gains         (gains_reg),
        .out_valid     (prod_valid),
        .out_ready     (res_ready),
        .prop_prod     (prop_prod),
        .deriv_prod    (deriv_prod),
        .integ_hi_prod (integ_hi_prod),
        .integ_lo_prod (integ_lo_prod)
    );

    // Summation, then sign, magnitude and clipping into the output register.
    pidv_result #(
        .SPEED_WIDTH (SPEED_WIDTH),
        .SUM_WIDTH   (SUM_WIDTH)
    ) u_result (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (prod_valid),
        .in_ready      (res_ready),
        .prop_prod     (prop_prod),
        .deriv_prod    (deriv_prod),
        .integ_hi_prod (integ_hi_prod),
        .integ_lo_prod (integ_lo_prod),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .direction     (m_direction),
        .duty          (m_duty)
    );

`ifndef SYNTHESIS
    // A beat held in the input register must survive a stall of the
    // integrator stage untouched.
    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !integ_ready) |=> (in_valid_reg && $stable(meas_reg)))
        else $error("input beat lost or changed while the integrator stalled");
`endif

endmodule

### src/pidv_integrator.sv
module pidv_integrator #(
    parameter int SPEED_WIDTH = 24,
    parameter int SUM_WIDTH   = 40
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SPEED_WIDTH-1:0] measured,
    input  logic signed [SPEED_WIDTH-1:0] target,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SPEED_WIDTH:0]   err,
    output logic signed [SPEED_WIDTH+1:0] diff,
    output logic signed [SUM_WIDTH-1:0]   sum
);

    localparam int ERR_W  = SPEED_WIDTH + 1;
    localparam int DIFF_W = SPEED_WIDTH + 2;
    localparam int EXT_W  = ((SUM_WIDTH > ERR_W) ? SUM_WIDTH : ERR_W) + 1;

    logic                 load;
    logic                 out_valid_reg;
    logic [ERR_W-1:0]     err_next;
    logic [DIFF_W-1:0]    diff_next;
    logic [EXT_W-1:0]     sum_ext;
    logic                 sat_hi;
    logic                 sat_lo;
    logic [SUM_WIDTH-1:0] sum_next;
    logic [SUM_WIDTH-1:0] sum_reg;
    logic [ERR_W-1:0]     last_err_reg;
    logic [DIFF_W-1:0]    diff_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    assign err_next  = {target[SPEED_WIDTH-1], target} - {measured[SPEED_WIDTH-1], measured};
    assign diff_next = {err_next[ERR_W-1], err_next} - {last_err_reg[ERR_W-1], last_err_reg};

    // The sum is widened by a guard bit so that overflow shows in the top bits.
    assign sum_ext = {{(EXT_W-SUM_WIDTH){sum_reg[SUM_WIDTH-1]}}, sum_reg}
                   + {{(EXT_W-ERR_W){err_next[ERR_W-1]}}, err_next};

    assign sat_hi = !sum_ext[EXT_W-1] && (sum_ext[EXT_W-2:SUM_WIDTH-1] != '0);
    assign sat_lo =  sum_ext[EXT_W-1] && (sum_ext[EXT_W-2:SUM_WIDTH-1] != '1);

    always_comb begin
        if (sat_hi) begin
            sum_next = {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end else if (sat_lo) begin
            sum_next = {1'b1, {(SUM_WIDTH-1){1'b0}}};
        end else begin
            sum_next = sum_ext[SUM_WIDTH-1:0];
        end
    end

    // The integrator and previous-error state doubles as this stage's output,
    // since both are loaded at the same time as the stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            last_err_reg  <= '0;
        end else begin
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
            if (load) begin
                sum_reg      <= sum_next;
                last_err_reg <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            diff_reg <= diff_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign err       = $signed(last_err_reg);
    assign diff      = $signed(diff_reg);
    assign sum       = $signed(sum_reg);

`ifndef SYNTHESIS
    // The controller state may only move when a beat enters the stage.
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !load |=> ($stable(sum_reg) && $stable(last_err_reg)))
        else $error("integrator state changed without a new beat");

    // Adding a non-negative error to a non-negative sum must never wrap negative.
    a_no_wrap_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !sum_reg[SUM_WIDTH-1] && !err_next[ERR_W-1]) |=> !sum_reg[SUM_WIDTH-1])
        else $error("integrator wrapped on positive overflow");
`endif

endmodule

### src/pidv_products.sv
module pidv_products #(
    parameter int SPEED_WIDTH = 24,
    parameter int SUM_WIDTH   = 40
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SPEED_WIDTH:0]   err,
    input  logic signed [SPEED_WIDTH+1:0] diff,
    input  logic signed [SUM_WIDTH-1:0]   sum,
    input  pidv_pkg::gains_t              gains,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [pidv_pkg::GAIN_W+SPEED_WIDTH+1:0]           prop_prod,
    output logic signed [pidv_pkg::GAIN_W+SPEED_WIDTH+2:0]           deriv_prod,
    output logic signed [pidv_pkg::GAIN_W+SUM_WIDTH-SUM_WIDTH/2:0]   integ_hi_prod,
    output logic        [pidv_pkg::GAIN_W+SUM_WIDTH/2-1:0]           integ_lo_prod
);
    import pidv_pkg::*;

    localparam int LO_W = SUM_WIDTH / 2;
    localparam int HI_W = SUM_WIDTH - LO_W;
    localparam int PP_W = GAIN_W + SPEED_WIDTH + 2;
    localparam int DP_W = GAIN_W + SPEED_WIDTH + 3;
    localparam int HP_W = GAIN_W + HI_W + 1;
    localparam int LP_W = GAIN_W + LO_W;

    logic                   load;
    logic                   out_valid_reg;
    logic signed [PP_W-1:0] prop_next;
    logic signed [DP_W-1:0] deriv_next;
    logic signed [HP_W-1:0] hi_next;
    logic        [LP_W-1:0] lo_next;
    logic signed [PP_W-1:0] prop_reg;
    logic signed [DP_W-1:0] deriv_reg;
    logic signed [HP_W-1:0] hi_reg;
    logic        [LP_W-1:0] lo_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // The wide integral is split into a signed upper half and an unsigned lower
    // half so that no multiplier is much wider than the gain.
    assign prop_next  = $signed({1'b0, gains.prop}) * err;
    assign deriv_next = $signed({1'b0, gains.deriv}) * diff;
    assign hi_next    = $signed({1'b0, gains.integ}) * $signed(sum[SUM_WIDTH-1:LO_W]);
    assign lo_next    = gains.integ * sum[LO_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prop_reg  <= prop_next;
            deriv_reg <= deriv_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign prop_prod     = prop_reg;
    assign deriv_prod    = deriv_reg;
    assign integ_hi_prod = hi_reg;
    assign integ_lo_prod = lo_reg;

endmodule

### src/pidv_result.sv
module pidv_result #(
    parameter int SPEED_WIDTH = 24,
    parameter int SUM_WIDTH   = 40
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [pidv_pkg::GAIN_W+SPEED_WIDTH+1:0]           prop_prod,
    input  logic signed [pidv_pkg::GAIN_W+SPEED_WIDTH+2:0]           deriv_prod,
    input  logic signed [pidv_pkg::GAIN_W+SUM_WIDTH-SUM_WIDTH/2:0]   integ_hi_prod,
    input  logic        [pidv_pkg::GAIN_W+SUM_WIDTH/2-1:0]           integ_lo_prod,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          direction,
    output logic [pidv_pkg::DUTY_W-1:0]   duty
);
    import pidv_pkg::*;

    localparam int LO_W  = SUM_WIDTH / 2;
    localparam int HI_W  = SUM_WIDTH - LO_W;
    localparam int PP_W  = GAIN_W + SPEED_WIDTH + 2;
    localparam int DP_W  = GAIN_W + SPEED_WIDTH + 3;
    localparam int HP_W  = GAIN_W + HI_W + 1;
    localparam int LP_W  = GAIN_W + LO_W;
    localparam int IP_W  = GAIN_W + SUM_WIDTH + 1;
    localparam int CTL_W = ((DP_W > IP_W) ? DP_W : IP_W) + 2;

    logic              ctl_load;
    logic              ctl_ready;
    logic              ctl_valid_reg;
    logic [CTL_W-1:0]  ctl_next;
    logic [CTL_W-1:0]  ctl_reg;
    logic              out_load;
    logic              out_valid_reg;
    logic [CTL_W-1:0]  mag;
    logic              clip;
    logic              dir_next;
    logic [DUTY_W-1:0] duty_next;
    logic              dir_reg;
    logic [DUTY_W-1:0] duty_reg;

    // Adder stage: the Q.28 control value, exact.
    assign in_ready = !ctl_valid_reg || ctl_ready;
    assign ctl_load = in_valid && in_ready;

    assign ctl_next = {{(CTL_W-PP_W){prop_prod[PP_W-1]}}, prop_prod}
                    + {{(CTL_W-DP_W){deriv_prod[DP_W-1]}}, deriv_prod}
                    + {{(CTL_W-HP_W-LO_W){integ_hi_prod[HP_W-1]}}, integ_hi_prod,
                       {LO_W{1'b0}}}
                    + {{(CTL_W-LP_W){1'b0}}, integ_lo_prod};

    // Output stage: sign, magnitude and clipping at full scale.
    assign ctl_ready = !out_valid_reg || out_ready;
    assign out_load  = ctl_valid_reg && ctl_ready;

    assign mag       = ctl_reg[CTL_W-1] ? (CTL_W'(0) - ctl_reg) : ctl_reg;
    assign clip      = (mag[CTL_W-1:CLIP_BIT] != '0);
    assign dir_next  = !ctl_reg[CTL_W-1] && (ctl_reg != '0);
    assign duty_next = clip ? {DUTY_W{1'b1}} : mag[CLIP_BIT-1:FRAC_SHIFT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                ctl_valid_reg <= in_valid;
            end
            if (ctl_ready) begin
                out_valid_reg <= ctl_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_load) begin
            ctl_reg <= ctl_next;
        end
        if (out_load) begin
            dir_reg  <= dir_next;
            duty_reg <= duty_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign direction = dir_reg;
    assign duty      = duty_reg;

`ifndef SYNTHESIS
    // A positive control value of 1.0 or more must come out at full scale.
    a_clip_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !ctl_reg[CTL_W-1] && (ctl_reg[CTL_W-1:CLIP_BIT] != '0))
        |=> (dir_reg && (duty_reg == {DUTY_W{1'b1}})))
        else $error("positive control above full scale not clipped");
`endif

endmodule

### dv/pidv_checker.sv
// Watches the tick and result channels of the PID speed controller, keeps its own
// copy of the gains, the target, the integral and the previous error, and checks
// every result beat against the command it expects for that tick.
module pidv_checker #(
    parameter int SPEED_WIDTH = 24,
    parameter int SUM_WIDTH   = 40
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic signed [SPEED_WIDTH-1:0] s_measured_speed,

    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_direction,
    input  logic [pidv_pkg::DUTY_W-1:0]   m_duty,

    input  logic                          cfg_we,
    input  pidv_pkg::reg_index_t          cfg_index,
    input  logic [pidv_pkg::CFG_DATA_W-1:0] cfg_wdata,

    output int                            fail_count,
    output int                            pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import pidv_pkg::*;

    typedef struct packed {
        logic              direction;
        logic [DUTY_W-1:0] duty;
    } motor_cmd_t;

    localparam logic signed [SUM_WIDTH:0] SUM_HI = {2'b00, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH:0] SUM_LO = {2'b11, {(SUM_WIDTH-1){1'b0}}};

    logic [GAIN_W-1:0]              kp;
    logic [GAIN_W-1:0]              ki_dt;
    logic [GAIN_W-1:0]              kd_dt;
    logic signed [SPEED_WIDTH-1:0]  target;
    logic signed [SUM_WIDTH-1:0]    integral;
    logic signed [SPEED_WIDTH:0]    prev_error;

    motor_cmd_t expected_cmds[$];
    int         failures = 0;

    // One control tick: update the integral and previous error, return the command.
    function automatic motor_cmd_t advance_control(input logic signed [SPEED_WIDTH-1:0] measured);
        logic signed [SPEED_WIDTH:0]   err;
        logic signed [SPEED_WIDTH+1:0] diff;
        logic signed [SUM_WIDTH:0]     sum_ext;
        logic signed [127:0]           acc;
        logic [127:0]                  mag;
        motor_cmd_t                    cmd;
        err     = target - measured;
        diff    = err - prev_error;
        sum_ext = integral + err;
        if (sum_ext > SUM_HI)
            sum_ext = SUM_HI;
        else if (sum_ext < SUM_LO)
            sum_ext = SUM_LO;
        integral   = sum_ext[SUM_WIDTH-1:0];
        prev_error = err;
        acc = $signed({1'b0, kp}) * err
            + $signed({1'b0, ki_dt}) * integral
            + $signed({1'b0, kd_dt}) * diff;
        cmd.direction = (acc > 0);
        mag = (acc < 0) ? -acc : acc;
        cmd.duty = ((mag >> CLIP_BIT) != 0) ? '1 : mag[CLIP_BIT-1:FRAC_SHIFT];
        return cmd;
    endfunction

    always @(posedge aclk) begin
        motor_cmd_t want;
        if (!aresetn) begin
            kp         = PROP_GAIN_RESET;
            ki_dt      = INTEG_GAIN_RESET;
            kd_dt      = DERIV_GAIN_RESET;
            target     = '0;
            integral   = '0;
            prev_error = '0;
            expected_cmds.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_PROP_GAIN:  kp     = cfg_wdata[GAIN_W-1:0];
                    REG_INTEG_GAIN: ki_dt  = cfg_wdata[GAIN_W-1:0];
                    REG_DERIV_GAIN: kd_dt  = cfg_wdata[GAIN_W-1:0];
                    REG_TARGET:     target = cfg_wdata[SPEED_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_cmds.push_back(advance_control(s_measured_speed));
            if (m_valid && m_ready) begin
                if (expected_cmds.size() == 0) begin
                    $display("%0t: result beat with nothing expected (direction %0d, duty %0d)",
                             $time, m_direction, m_duty);
                    failures++;
                end else begin
                    want = expected_cmds.pop_front();
                    if (m_direction !== want.direction) begin
                        $display("%0t: direction mismatch: expected %0d, got %0d",
                                 $time, want.direction, m_direction);
                        failures++;
                    end
                    if (m_duty !== want.duty) begin
                        $display("%0t: duty mismatch: expected %0d, got %0d",
                                 $time, want.duty, m_duty);
                        failures++;
                    end
                end
            end
        end
        pending_count <= expected_cmds.size();
        fail_count    <= failures;
    end

endmodule

### dv/testbench.sv
// Top level of the testbench. It generates clock and reset, drives control ticks
// and configuration writes, applies back-pressure on the result channel, and
// delivers the verdict. All prediction and comparison lives in the checker.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import pidv_pkg::*;

    localparam int SPEED_WIDTH       = 24;
    localparam int SUM_WIDTH         = 40;
    // The block has a five-stage pipeline; this margin covers it comfortably.
    localparam int SETTLE_CYCLES     = 10;
    // A correct run never goes anywhere near this long without a beat.
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int RANDOM_SETTINGS   = 10;
    localparam int TICKS_PER_SETTING = 190;
    // Enough full-scale errors to carry the integral well past the point where
    // the duty clips, in either direction.
    localparam int SOAK_TICKS        = 30;

    localparam logic signed [SPEED_WIDTH-1:0] SPEED_MAX = {1'b0, {(SPEED_WIDTH-1){1'b1}}};
    localparam logic signed [SPEED_WIDTH-1:0] SPEED_MIN = {1'b1, {(SPEED_WIDTH-1){1'b0}}};
    localparam logic [GAIN_W-1:0]             GAIN_MAX  = '1;
    localparam logic [GAIN_W-1:0]             GAIN_ONE  = 32'h0001_0000;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;

    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic signed [SPEED_WIDTH-1:0] s_measured_speed = '0;

    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_direction;
    logic [DUTY_W-1:0]             m_duty;

    logic                          cfg_we = 1'b0;
    reg_index_t                    cfg_index = REG_PROP_GAIN;
    logic [CFG_DATA_W-1:0]         cfg_wdata = '0;

    int  fail_count;
    int  pending_count;

    // When clear, neither side inserts gaps or stalls.
    bit  idle_on = 1'b0;

    int  ticks_sent = 0;
    int  results_seen = 0;
    int  settings_applied = 0;
    int  quiet_cycles = 0;

    logic signed [SPEED_WIDTH-1:0] cur_target = '0;
    logic signed [SPEED_WIDTH-1:0] last_speed = '0;

    always #10 aclk = ~aclk;

    pid_velocity_controller #(
        .SPEED_WIDTH (SPEED_WIDTH),
        .SUM_WIDTH   (SUM_WIDTH)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_measured_speed (s_measured_speed),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_direction      (m_direction),
        .m_duty           (m_duty),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    pidv_checker #(
        .SPEED_WIDTH (SPEED_WIDTH),
        .SUM_WIDTH   (SUM_WIDTH)
    ) control_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_measured_speed (s_measured_speed),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_direction      (m_direction),
        .m_duty           (m_duty),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .fail_count       (fail_count),
        .pending_count    (pending_count)
    );

    // Watchdog: any beat on either channel restarts the count. A run that hangs
    // ends here rather than spinning forever.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid === 1'b1 && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (m_valid === 1'b1 && m_ready)
            results_seen <= results_seen + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a beat", quiet_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: before each beat the receiver may hold m_ready low for a
    // random number of cycles, then keeps it high until a beat is taken.
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = idle_on ? $urandom_range(0, 6) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_ready && m_valid === 1'b1));
        end
    end

    // Present one tick, after an optional gap, and hold it until the block
    // takes the beat. Valid is left high so that back-to-back ticks need no
    // second assignment within the same step.
    task automatic send_tick(input logic signed [SPEED_WIDTH-1:0] speed);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_measured_speed <= speed;
        do @(posedge aclk); while (!(s_valid && s_ready));
        last_speed = speed;
        ticks_sent++;
    endtask

    // Stop sending, let every outstanding result drain, then allow the pipeline
    // to empty completely before anything else happens.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all four registers on consecutive cycles while the block is idle.
    // The unused upper bits of the target word carry random junk, which the
    // block must ignore.
    task automatic apply_settings(input logic [GAIN_W-1:0] prop,
                                  input logic [GAIN_W-1:0] integ,
                                  input logic [GAIN_W-1:0] deriv,
                                  input logic signed [SPEED_WIDTH-1:0] target);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_PROP_GAIN;
        cfg_wdata <= prop;
        @(posedge aclk);
        cfg_index <= REG_INTEG_GAIN;
        cfg_wdata <= integ;
        @(posedge aclk);
        cfg_index <= REG_DERIV_GAIN;
        cfg_wdata <= deriv;
        @(posedge aclk);
        cfg_index <= REG_TARGET;
        cfg_wdata <= {(CFG_DATA_W-SPEED_WIDTH)'($urandom), target};
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_target = target;
        settings_applied++;
    endtask

    // Gains are mostly modest so that the duty is often unclipped; the extremes
    // and fully random values turn up now and then.
    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return GAIN_MAX;
            5:       return $urandom;
            default: return $urandom_range(0, 1 << 17);
        endcase
    endfunction

    function automatic logic signed [SPEED_WIDTH-1:0] pick_target();
        case ($urandom_range(0, 5))
            0:       return SPEED_MIN;
            1:       return SPEED_MAX;
            2:       return '0;
            5:       return SPEED_WIDTH'($urandom);
            default: return SPEED_WIDTH'($signed(SPEED_WIDTH'($urandom_range(0, 1 << 17)))
                                         - (1 << 16));
        endcase
    endfunction

    // Most measurements sit close to the target, with an error whose size is
    // drawn over every bit width, so the controller spends time in its linear
    // region. The rest are arbitrary speeds, the extremes or zero, or a repeat of the
    // previous speed, which leaves the derivative term at zero.
    function automatic logic signed [SPEED_WIDTH-1:0] pick_speed();
        logic signed [SPEED_WIDTH-1:0] delta;
        int                            choice;
        choice = $urandom_range(0, 9);
        if (choice < 6) begin
            delta = SPEED_WIDTH'($urandom);
            delta = delta >>> (SPEED_WIDTH - $urandom_range(1, SPEED_WIDTH));
            return cur_target + delta;
        end else if (choice < 8) begin
            return SPEED_WIDTH'($urandom);
        end else if (choice == 8) begin
            case ($urandom_range(0, 2))
                0:       return SPEED_MIN;
                1:       return SPEED_MAX;
                default: return '0;
            endcase
        end
        return last_speed;
    endfunction

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed ticks on the reset gains and a zero target. A zero error
        // gives exactly zero control; errors of one LSB either way give a tiny
        // command in each direction; the speed extremes drive the duty into the
        // clip, and the derivative term keeps it there for the moderate speeds.
        idle_on = 1'b0;
        send_tick('0);
        send_tick(SPEED_WIDTH'(-1));
        send_tick(SPEED_WIDTH'(1));
        send_tick(SPEED_MAX);
        send_tick(SPEED_MIN);
        send_tick(SPEED_WIDTH'(-40000));
        send_tick(SPEED_WIDTH'(40000));
        send_tick('0);
        send_tick('0);

        // All gains zero: a large error must still give zero control.
        apply_settings('0, '0, '0, SPEED_MAX);
        send_tick(SPEED_MIN);
        send_tick('0);

        // All gains at their maximum with the most negative target.
        apply_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, SPEED_MIN);
        send_tick(SPEED_MAX);
        send_tick(SPEED_MIN);
        send_tick(SPEED_MIN);

        // Proportional gain of exactly 1.0: an error of 4095/4096 sits one
        // step below full scale, and 4096/4096 lands exactly on 1.0, in both
        // directions.
        apply_settings(GAIN_ONE, '0, '0, '0);
        send_tick(SPEED_WIDTH'(-4095));
        send_tick(SPEED_WIDTH'(-4096));
        send_tick(SPEED_WIDTH'(4096));
        send_tick(SPEED_WIDTH'(4095));

        // Random part: a fresh set of gains and target for each phase, with
        // the first phase run flat out and the others mostly with idling.
        for (int phase = 0; phase < RANDOM_SETTINGS; phase++) begin
            apply_settings(pick_gain(), pick_gain(), pick_gain(), pick_target());
            idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
            repeat (TICKS_PER_SETTING) send_tick(pick_speed());
        end

        // Integral sweep: with only an integral gain of one LSB the command is
        // the integral itself. Full-scale errors drive it deep into the positive
        // clip, then down through zero into the negative clip and back, so the
        // duty passes through its linear window on each crossing of zero.
        idle_on = 1'b0;
        apply_settings('0, 32'd1, '0, SPEED_MAX);
        repeat (SOAK_TICKS) send_tick(SPEED_MIN);
        apply_settings('0, 32'd1, '0, SPEED_MIN);
        repeat (2 * SOAK_TICKS) send_tick(SPEED_MAX);
        apply_settings('0, 32'd1, '0, SPEED_MAX);
        repeat (SOAK_TICKS) send_tick(SPEED_MIN);

        settle();

        $display("Covered %0d ticks under %0d register settings; %0d result beats checked.",
                 ticks_sent, settings_applied + 1, results_seen);
        $display("Included gain and speed extremes, random idling and integral sweeps.");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
